/* rtl/core/nand_flash_command_engine_core_assert.svh */
// assertion macros for the bound property checker
`ifndef NAND_FLASH_COMMAND_ENGINE_CORE_ASSERT_SVH
`define NAND_FLASH_COMMAND_ENGINE_CORE_ASSERT_SVH

// antecedent in one cycle, consequent in the next, quiet while in reset
`define NFCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nfce check failed");

// same form, also checked across reset
`define NFCE_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("nfce reset check failed");

`endif

/* rtl/core/nfce_pkg.sv */
package nfce_pkg;

  typedef struct packed {
    logic       action;
    logic       cle;
    logic       ale;
    logic [7:0] write_data;
  } nfce_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       protocol_error;
  } nfce_out_t;

  localparam int PAGE_BYTES  = 528;
  localparam int SPARE_BYTES = 16;
  localparam int SPARE_COL   = 512;
  localparam int HALF_COL    = 256;
  localparam int PAGE_W      = 17;
  localparam int OFF_W       = 27;
  localparam int SEQ_W       = 20;
  localparam int COL_W       = 10;
  localparam int CNT_SAT     = 15;

  localparam logic [7:0] CMD_READ0      = 8'h00;
  localparam logic [7:0] CMD_READ1      = 8'h01;
  localparam logic [7:0] CMD_READ_SPARE = 8'h50;
  localparam logic [7:0] CMD_ERASE      = 8'h60;
  localparam logic [7:0] CMD_STATUS     = 8'h70;
  localparam logic [7:0] CMD_READ_ID    = 8'h90;
  localparam logic [7:0] CMD_RESET      = 8'hFF;
  localparam logic [7:0] CMD_PROG       = 8'h80;
  localparam logic [7:0] CMD_PROG_CONF  = 8'h10;
  localparam logic [7:0] CMD_ERASE_CONF = 8'hD0;

  localparam logic [7:0] STATUS_READY = 8'h40;
  localparam logic [7:0] ID_MAKER     = 8'hEC;
  localparam logic [7:0] ID_DEVICE    = 8'h75;
  localparam logic [7:0] BYTE_ERASED  = 8'hFF;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_MUL,
    ST_RD_OFF,
    ST_RD_MEM,
    ST_RD_OUT,
    ST_PG_MUL,
    ST_PG_OFF,
    ST_PG_RD,
    ST_PG_WR,
    ST_ER_DIV,
    ST_ER_MUL,
    ST_ER_WR
  } nfce_state_t;

endpackage

/* rtl/core/nfce_ram.sv */
module nfce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/nand_flash_command_engine_core.sv */
// channel | ports                              | handshake
// input   | start, busy, in_item               | taken when start is high and busy is low
// result  | out_valid, out_item                | one-cycle strobe, receiver cannot stall
// config  | cfg_wr_en, cfg_wr_data             | force_overwrite written when cfg_wr_en is high
//
// register-only accesses answer in the cycle after they are taken, busy stays low
// array reads hold busy and answer from the last of the read states, in this order:
//   page multiply, offset add, memory read, output
// program confirm answers next cycle, busy through page multiply, offset add, one rmw per byte (528 or 16)
// erase confirm answers once the block start is found and holds busy through its steps:
//   reciprocal multiply for the block start, then a byte sweep
// after reset a clearing pass writes 0xFF over NUM_PAGES*528 bytes, busy high throughout
module nand_flash_command_engine_core import nfce_pkg::*; #(
  parameter int NUM_PAGES    = 1024,
  parameter int BLOCK_PAGES  = 32,
  parameter int BUFFER_BYTES = 544
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  nfce_in_t  in_item,
  output logic      out_valid,
  output nfce_out_t out_item,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  localparam int FLASH_BYTES = NUM_PAGES * PAGE_BYTES;
  localparam int AW          = $clog2(FLASH_BYTES);
  localparam int BW          = $clog2(BUFFER_BYTES);
  localparam int BCW         = $clog2(BUFFER_BYTES + 1);
  localparam int ER_BYTES    = BLOCK_PAGES * PAGE_BYTES;
  localparam int CW          = $clog2(ER_BYTES);
  // reciprocal of the block size, exact for every 17-bit page and block sizes up to 64
  localparam int     ER_SH    = PAGE_W + 7;
  localparam int     RCW      = ER_SH + 1;
  localparam int     QPW      = PAGE_W + RCW;
  localparam longint ER_RECIP = ((longint'(1) << ER_SH) + BLOCK_PAGES - 1) / BLOCK_PAGES;

  // fsm
  nfce_state_t state_r, state_nxt;

  // command sequencing state
  logic [7:0]     cmd0_r, cmd0_nxt;
  logic [7:0]     cmd1_r, cmd1_nxt;
  logic [3:0]     cmd_cnt_r, cmd_cnt_nxt;
  logic [7:0]     addr_r [4];
  logic [7:0]     addr_nxt [4];
  logic [3:0]     addr_cnt_r, addr_cnt_nxt;
  logic [BCW-1:0] buf_cnt_r, buf_cnt_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;

  // config, and a copy frozen for the running program
  logic force_r, force_op_r, force_op_nxt;

  // byte walk datapath
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [OFF_W-1:0]  prod_r, prod_nxt;
  logic [OFF_W-1:0]  cur_r, cur_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     last_r, last_nxt;
  logic              oor_r, oor_nxt;
  logic [PAGE_W-1:0] quo_r, quo_nxt;

  // result register
  logic      out_valid_r, out_valid_nxt;
  nfce_out_t out_r, out_nxt;

  // memory ports
  logic          flash_we;
  logic [AW-1:0] flash_waddr, flash_raddr;
  logic [7:0]    flash_wdata, flash_rdata;
  logic          buf_we;
  logic [BW-1:0] buf_waddr, buf_raddr;
  logic [7:0]    buf_wdata, buf_rdata;

  logic              accept;
  logic              go_read, go_prog, go_erase;
  logic [PAGE_W-1:0] row_page, erase_page, blk_first;
  logic [QPW-1:0]    quo_prod;
  logic              in_range;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_item   = out_r;
  // row address for reads and programs, block address for erase
  assign row_page   = {addr_r[3][0], addr_r[2], addr_r[1]};
  assign erase_page = {addr_r[2][0], addr_r[1], addr_r[0]};
  // block number by reciprocal multiply, then back to the first page of the block
  assign quo_prod   = QPW'(erase_page) * QPW'(ER_RECIP);
  assign blk_first  = quo_r * PAGE_W'(BLOCK_PAGES);
  assign in_range   = (cur_r < OFF_W'(FLASH_BYTES));

  nfce_ram #(.WIDTH(8), .DEPTH(FLASH_BYTES)) u_flash (
    .clk   (clk),
    .we    (flash_we),
    .waddr (flash_waddr),
    .wdata (flash_wdata),
    .raddr (flash_raddr),
    .rdata (flash_rdata)
  );

  nfce_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_page_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (cur_r == OFF_W'(FLASH_BYTES - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (go_read) state_nxt = ST_RD_MUL;
        else if (go_prog) state_nxt = ST_PG_MUL;
        else if (go_erase) state_nxt = ST_ER_DIV;
      end
      ST_RD_MUL: state_nxt = ST_RD_OFF;
      ST_RD_OFF: state_nxt = ST_RD_MEM;
      ST_RD_MEM: state_nxt = ST_RD_OUT;
      ST_RD_OUT: state_nxt = ST_IDLE;
      ST_PG_MUL: state_nxt = ST_PG_OFF;
      ST_PG_OFF: state_nxt = ST_PG_RD;
      ST_PG_RD:  state_nxt = ST_PG_WR;
      ST_PG_WR: begin
        state_nxt = (idx_r == last_r) ? ST_IDLE : ST_PG_RD;
      end
      ST_ER_DIV: state_nxt = ST_ER_MUL;
      ST_ER_MUL: state_nxt = ST_ER_WR;
      ST_ER_WR: begin
        if (idx_r == last_r) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // decode, datapath and memory control
  always_comb begin
    logic [7:0] v;
    logic [7:0] c0;
    logic [7:0] res;
    logic       err;
    logic       respond;
    logic       do_push;

    v        = in_item.write_data;
    c0       = cmd0_r;
    res      = BYTE_ERASED;
    err      = 1'b0;
    respond  = 1'b0;
    do_push  = 1'b0;
    go_read  = 1'b0;
    go_prog  = 1'b0;
    go_erase = 1'b0;

    cmd0_nxt     = cmd0_r;
    cmd1_nxt     = cmd1_r;
    cmd_cnt_nxt  = cmd_cnt_r;
    addr_nxt     = addr_r;
    addr_cnt_nxt = addr_cnt_r;
    buf_cnt_nxt  = buf_cnt_r;
    seq_nxt      = seq_r;
    force_op_nxt = force_op_r;
    col_nxt      = col_r;
    prod_nxt     = prod_r;
    cur_nxt      = cur_r;
    idx_nxt      = idx_r;
    last_nxt     = last_r;
    oor_nxt      = oor_r;
    quo_nxt      = quo_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    flash_we    = 1'b0;
    flash_waddr = cur_r[AW-1:0];
    flash_wdata = BYTE_ERASED;
    flash_raddr = cur_r[AW-1:0];
    buf_we      = 1'b0;
    buf_waddr   = BW'(buf_cnt_r);
    buf_wdata   = v;
    buf_raddr   = BW'(idx_r);

    case (state_r)
      // sweep the whole array to the erased value
      ST_CLEAR: begin
        flash_we = 1'b1;
        cur_nxt  = cur_r + OFF_W'(1);
      end

      ST_IDLE: begin
        if (accept) begin
          respond = 1'b1;
          if (!in_item.action) begin
            // read strobe
            if (cmd_cnt_r == 4'd0) begin
              res = BYTE_ERASED;
            end else if (c0 == CMD_STATUS && cmd_cnt_r == 4'd1 && addr_cnt_r == 4'd0 &&
                         buf_cnt_r == '0) begin
              res = STATUS_READY;
              cmd_cnt_nxt  = 4'd0;
              addr_cnt_nxt = 4'd0;
              buf_cnt_nxt  = '0;
              seq_nxt      = '0;
            end else if (c0 == CMD_READ_ID && cmd_cnt_r == 4'd1 && addr_cnt_r == 4'd1 &&
                         addr_r[0] == BYTE_ZERO && buf_cnt_r == '0) begin
              if (seq_r == '0) begin
                res     = ID_MAKER;
                seq_nxt = SEQ_W'(1);
              end else if (seq_r == SEQ_W'(1)) begin
                res = ID_DEVICE;
                cmd_cnt_nxt  = 4'd0;
                addr_cnt_nxt = 4'd0;
                buf_cnt_nxt  = '0;
                seq_nxt      = '0;
              end else begin
                res = BYTE_ZERO;
                err = 1'b1;
              end
            end else if (c0 != CMD_READ0 && c0 != CMD_READ1 && c0 != CMD_READ_SPARE &&
                         c0 != CMD_ERASE) begin
              res = BYTE_ZERO;
              err = 1'b1;
            end else if (c0 == CMD_ERASE || cmd_cnt_r != 4'd1 || addr_cnt_r != 4'd4 ||
                         buf_cnt_r != '0) begin
              res = BYTE_ERASED;
              err = 1'b1;
            end else begin
              // array read, answered from the read states
              respond = 1'b0;
              go_read = 1'b1;
              if (c0 == CMD_READ1) col_nxt = COL_W'(HALF_COL);
              else if (c0 == CMD_READ_SPARE) col_nxt = COL_W'(SPARE_COL);
              else col_nxt = '0;
            end
          end else if (in_item.cle && in_item.ale) begin
            // both latches high: ignored
            err = 1'b0;
          end else if (in_item.cle) begin
            if (v == CMD_RESET || v == CMD_READ0 || v == CMD_READ1 || v == CMD_READ_SPARE ||
                v == CMD_ERASE || v == CMD_STATUS || v == CMD_READ_ID) begin
              // a new command is fine with no command pending, over a complete read setup or over a confirmed erase
              if (cmd_cnt_r != 4'd0) begin
                if (cmd_cnt_r == 4'd1 && addr_cnt_r == 4'd4 && buf_cnt_r == '0)
                  err = !(c0 == CMD_READ0 || c0 == CMD_READ1 || c0 == CMD_READ_SPARE);
                else if (cmd_cnt_r == 4'd2 && addr_cnt_r == 4'd3 && buf_cnt_r == '0)
                  err = (c0 != CMD_ERASE);
                else
                  err = 1'b1;
              end
              addr_cnt_nxt = 4'd0;
              buf_cnt_nxt  = '0;
              seq_nxt      = '0;
              cmd0_nxt     = v;
              cmd_cnt_nxt  = (v == CMD_RESET) ? 4'd0 : 4'd1;
            end else if (v == CMD_PROG_CONF) begin
              if (cmd_cnt_r != 4'd2 || addr_cnt_r != 4'd4) begin
                err = 1'b1;
              end else if ((c0 == CMD_READ_SPARE && buf_cnt_r == BCW'(SPARE_BYTES)) ||
                           (c0 == CMD_READ0 && buf_cnt_r == BCW'(PAGE_BYTES))) begin
                // program still runs at a nonzero column, but flags it
                err          = (cmd1_r != CMD_PROG) || (addr_r[0] != BYTE_ZERO);
                go_prog      = 1'b1;
                force_op_nxt = force_r;
                if (c0 == CMD_READ_SPARE) begin
                  col_nxt  = COL_W'(SPARE_COL);
                  last_nxt = CW'(SPARE_BYTES - 1);
                end else begin
                  col_nxt  = '0;
                  last_nxt = CW'(PAGE_BYTES - 1);
                end
                cmd_cnt_nxt  = 4'd0;
                addr_cnt_nxt = 4'd0;
                buf_cnt_nxt  = '0;
                seq_nxt      = '0;
              end else begin
                err = 1'b1;
              end
            end else if (v == CMD_ERASE_CONF) begin
              if (cmd_cnt_r != 4'd1 || c0 != CMD_ERASE || addr_cnt_r != 4'd3 ||
                  buf_cnt_r != '0) begin
                err = 1'b1;
              end else begin
                // result waits for the alignment check
                respond  = 1'b0;
                go_erase = 1'b1;
                seq_nxt  = seq_r + SEQ_W'(1);
              end
              do_push = 1'b1;
            end else if (v == CMD_PROG) begin
              err = (cmd_cnt_r == 4'd0) || (c0 != CMD_READ_SPARE && c0 != CMD_READ0) ||
                    (addr_cnt_r != 4'd0) || (buf_cnt_r != '0);
              do_push = 1'b1;
            end else begin
              err = 1'b1;
            end
          end else if (in_item.ale) begin
            err = (cmd_cnt_r == 4'd0);
            if (addr_cnt_r < 4'd4) addr_nxt[addr_cnt_r[1:0]] = v;
            if (addr_cnt_r < 4'(CNT_SAT)) addr_cnt_nxt = addr_cnt_r + 4'd1;
          end else if (cmd_cnt_r == 4'd0) begin
            // data with no command is dropped
            err = 1'b1;
          end else begin
            if (c0 == CMD_READ_SPARE || c0 == CMD_READ0)
              err = !(cmd_cnt_r >= 4'd2 && cmd1_r == CMD_PROG);
            else
              err = 1'b1;
            if (buf_cnt_r < BCW'(BUFFER_BYTES)) begin
              buf_we      = 1'b1;
              buf_cnt_nxt = buf_cnt_r + BCW'(1);
            end
          end

          // command byte push with saturating count
          if (do_push) begin
            if (cmd_cnt_r == 4'd0) cmd0_nxt = v;
            else if (cmd_cnt_r == 4'd1) cmd1_nxt = v;
            if (cmd_cnt_r < 4'(CNT_SAT)) cmd_cnt_nxt = cmd_cnt_r + 4'd1;
          end

          if (respond) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{read_data: res, protocol_error: err};
          end
        end
      end

      // array read: page*528, then column and sequential offset
      ST_RD_MUL: begin
        prod_nxt = OFF_W'(row_page) * OFF_W'(PAGE_BYTES);
      end
      ST_RD_OFF: begin
        cur_nxt = prod_r + OFF_W'(addr_r[0]) + OFF_W'(seq_r) + OFF_W'(col_r);
        seq_nxt = seq_r + SEQ_W'(1);
      end
      ST_RD_MEM: begin
        oor_nxt = !in_range;
      end
      ST_RD_OUT: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{read_data: (oor_r ? BYTE_ERASED : flash_rdata),
                          protocol_error: 1'b0};
      end

      // program: read array byte and buffer byte, then write back
      ST_PG_MUL: begin
        prod_nxt = OFF_W'(row_page) * OFF_W'(PAGE_BYTES);
      end
      ST_PG_OFF: begin
        cur_nxt = prod_r + OFF_W'(addr_r[0]) + OFF_W'(col_r);
        idx_nxt = '0;
      end
      ST_PG_RD: begin
        // reads issued on the default ports
      end
      ST_PG_WR: begin
        flash_we    = in_range;
        flash_wdata = force_op_r ? buf_rdata : (flash_rdata & buf_rdata);
        cur_nxt     = cur_r + OFF_W'(1);
        idx_nxt     = idx_r + CW'(1);
      end

      // erase: block number of the page, then its first byte
      ST_ER_DIV: begin
        quo_nxt = quo_prod[ER_SH +: PAGE_W];
      end
      ST_ER_MUL: begin
        cur_nxt  = OFF_W'(quo_r) * OFF_W'(ER_BYTES);
        idx_nxt  = '0;
        last_nxt = CW'(ER_BYTES - 1);
        // unaligned block address still erases, flagged
        out_valid_nxt = 1'b1;
        out_nxt       = '{read_data: BYTE_ERASED, protocol_error: (blk_first != erase_page)};
      end
      ST_ER_WR: begin
        flash_we = in_range;
        cur_nxt  = cur_r + OFF_W'(1);
        idx_nxt  = idx_r + CW'(1);
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cur_r       <= '0;
      cmd0_r      <= '0;
      cmd1_r      <= '0;
      cmd_cnt_r   <= '0;
      addr_r      <= '{default: '0};
      addr_cnt_r  <= '0;
      buf_cnt_r   <= '0;
      seq_r       <= '0;
      force_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      cmd0_r      <= cmd0_nxt;
      cmd1_r      <= cmd1_nxt;
      cmd_cnt_r   <= cmd_cnt_nxt;
      addr_r      <= addr_nxt;
      addr_cnt_r  <= addr_cnt_nxt;
      buf_cnt_r   <= buf_cnt_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) force_r <= cfg_wr_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    force_op_r <= force_op_nxt;
    col_r      <= col_nxt;
    prod_r     <= prod_nxt;
    idx_r      <= idx_nxt;
    last_r     <= last_nxt;
    oor_r      <= oor_nxt;
    quo_r      <= quo_nxt;
    out_r      <= out_nxt;
  end

endmodule

/* rtl/core/nfce_checker.sv */
`include "nand_flash_command_engine_core_assert.svh"

module nfce_props import nfce_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input nfce_in_t  in_item,
  input logic      out_valid,
  input nfce_out_t out_item
);

  logic take;
  logic both_wr;
  logic plain_wr;

  assign take     = start && !busy;
  assign both_wr  = take && in_item.action && in_item.cle && in_item.ale;
  assign plain_wr = take && in_item.action && !in_item.cle;

  // clearing pass holds the block busy right after reset
  `NFCE_ASSERT_RST(a_rst_busy, !rst_n, busy)
  `NFCE_ASSERT_RST(a_rst_quiet, !rst_n, !out_valid)
  // write with both latches is ignored and answered next cycle
  `NFCE_ASSERT_NEXT(a_both_latch, both_wr, out_valid && out_item == '{BYTE_ERASED, 1'b0})
  // address and data writes answer 0xff the next cycle
  `NFCE_ASSERT_NEXT(a_write_ff, plain_wr, out_valid && out_item.read_data == BYTE_ERASED)

endmodule

bind nand_flash_command_engine_core nfce_props u_nfce_props (.*);

/* tb/nfce_checker.sv */
module nfce_checker import nfce_pkg::*; #(
  parameter int NUM_PAGES    = 1024,
  parameter int BLOCK_PAGES  = 32,
  parameter int BUFFER_BYTES = 544
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  nfce_in_t  in_item,
  input  logic      out_valid,
  input  nfce_out_t out_item,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ARRAY_BYTES = longint'(NUM_PAGES) * PAGE_BYTES;
  localparam int SEQ_MASK = (1 << SEQ_W) - 1;

  logic [7:0] flash_mem [ARRAY_BYTES];
  logic [7:0] cmd_hist [2];
  int         cmd_cnt;
  logic [7:0] addr_hist [4];
  int         addr_cnt;
  logic [7:0] data_buf [BUFFER_BYTES];
  int         data_cnt;
  int         seq_cnt;
  logic       overwrite;
  nfce_out_t  expected_q [$];

  assign pending = expected_q.size();

  initial begin
    foreach (flash_mem[i]) flash_mem[i] = BYTE_ERASED;
    fail_count = 0;
  end

  function automatic void clear_counts();
    cmd_cnt  = 0;
    addr_cnt = 0;
    data_cnt = 0;
    seq_cnt  = 0;
  endfunction

  function automatic logic [7:0] array_byte(longint off);
    if (off / PAGE_BYTES >= NUM_PAGES) return BYTE_ERASED;
    return flash_mem[off];
  endfunction

  function automatic void program_byte(longint off, logic [7:0] v);
    if (off / PAGE_BYTES >= NUM_PAGES) return;
    flash_mem[off] = overwrite ? v : (flash_mem[off] & v);
  endfunction

  function automatic longint row_page();
    return (longint'(addr_hist[3][0]) << 16) | (longint'(addr_hist[2]) << 8) | addr_hist[1];
  endfunction

  function automatic void latch_cmd(logic [7:0] v);
    if (cmd_cnt < 2) cmd_hist[cmd_cnt] = v;
    if (cmd_cnt < CNT_SAT) cmd_cnt++;
  endfunction

  function automatic logic read_access(output logic [7:0] r);
    logic [7:0] c0;
    longint off;
    c0 = cmd_hist[0];
    if (cmd_cnt == 0) begin
      r = BYTE_ERASED;
      return 0;
    end
    if (c0 == CMD_STATUS && cmd_cnt == 1 && addr_cnt == 0 && data_cnt == 0) begin
      clear_counts();
      r = STATUS_READY;
      return 0;
    end
    if (c0 == CMD_READ_ID && cmd_cnt == 1 && addr_cnt == 1 && addr_hist[0] == 0 &&
        data_cnt == 0) begin
      if (seq_cnt == 0) begin
        seq_cnt = 1;
        r = ID_MAKER;
        return 0;
      end
      if (seq_cnt == 1) begin
        clear_counts();
        r = ID_DEVICE;
        return 0;
      end
      r = BYTE_ZERO;
      return 1;
    end
    if (c0 != CMD_READ0 && c0 != CMD_READ1 && c0 != CMD_READ_SPARE && c0 != CMD_ERASE) begin
      r = BYTE_ZERO;
      return 1;
    end
    if (c0 == CMD_ERASE || cmd_cnt != 1 || addr_cnt != 4 || data_cnt != 0) begin
      r = BYTE_ERASED;
      return 1;
    end
    off = row_page() * PAGE_BYTES + addr_hist[0] + seq_cnt;
    if (c0 == CMD_READ1) off += HALF_COL;
    if (c0 == CMD_READ_SPARE) off += SPARE_COL;
    r = array_byte(off);
    seq_cnt = (seq_cnt + 1) & SEQ_MASK;
    return 0;
  endfunction

  function automatic logic program_confirm();
    longint base;
    int n;
    logic err;
    err = 0;
    if (cmd_cnt != 2 || addr_cnt != 4) return 1;
    if (cmd_hist[0] == CMD_READ_SPARE && data_cnt == SPARE_BYTES) begin
      base = row_page() * PAGE_BYTES + addr_hist[0] + SPARE_COL;
      n = SPARE_BYTES;
    end else if (cmd_hist[0] == CMD_READ0 && data_cnt == PAGE_BYTES) begin
      base = row_page() * PAGE_BYTES + addr_hist[0];
      n = PAGE_BYTES;
    end else begin
      return 1;
    end
    if (cmd_hist[1] != CMD_PROG || addr_hist[0] != 0) err = 1;
    for (int i = 0; i < n; i++) program_byte(base + i, data_buf[i]);
    clear_counts();
    return err;
  endfunction

  function automatic logic erase_confirm();
    longint pg, first;
    logic err;
    err = 0;
    if (cmd_cnt != 1 || cmd_hist[0] != CMD_ERASE || addr_cnt != 3 || data_cnt != 0) return 1;
    pg = (longint'(addr_hist[2][0]) << 16) | (longint'(addr_hist[1]) << 8) | addr_hist[0];
    first = pg - pg % BLOCK_PAGES;
    if (first != pg) err = 1;
    for (longint p = first; p < first + BLOCK_PAGES; p++)
      if (p < NUM_PAGES)
        for (int b = 0; b < PAGE_BYTES; b++) flash_mem[p * PAGE_BYTES + b] = BYTE_ERASED;
    seq_cnt = (seq_cnt + 1) & SEQ_MASK;
    return err;
  endfunction

  function automatic logic command_write(logic [7:0] v);
    logic err;
    logic [7:0] c0;
    err = 0;
    if (v inside {CMD_RESET, CMD_READ0, CMD_READ1, CMD_READ_SPARE, CMD_ERASE, CMD_STATUS,
                  CMD_READ_ID}) begin
      if (cmd_cnt > 0) begin
        c0 = cmd_hist[0];
        if (cmd_cnt == 1 && addr_cnt == 4 && data_cnt == 0)
          err = !(c0 == CMD_READ0 || c0 == CMD_READ1 || c0 == CMD_READ_SPARE);
        else if (cmd_cnt == 2 && addr_cnt == 3 && data_cnt == 0)
          err = (c0 != CMD_ERASE);
        else
          err = 1;
      end
      clear_counts();
      if (v != CMD_RESET) latch_cmd(v);
      return err;
    end
    if (v == CMD_PROG_CONF) return program_confirm();
    if (v == CMD_ERASE_CONF) begin
      err = erase_confirm();
      latch_cmd(v);
      return err;
    end
    if (v == CMD_PROG) begin
      if (cmd_cnt < 1 || (cmd_hist[0] != CMD_READ_SPARE && cmd_hist[0] != CMD_READ0) ||
          addr_cnt != 0 || data_cnt != 0)
        err = 1;
      latch_cmd(v);
      return err;
    end
    return 1;
  endfunction

  // one bus access in, one expected answer out
  function automatic nfce_out_t flash_access(nfce_in_t it);
    nfce_out_t r;
    r.read_data = BYTE_ERASED;
    r.protocol_error = 0;
    if (!it.action) begin
      r.protocol_error = read_access(r.read_data);
    end else if (it.cle && it.ale) begin
      r.protocol_error = 0;
    end else if (it.cle) begin
      r.protocol_error = command_write(it.write_data);
    end else if (it.ale) begin
      if (cmd_cnt == 0) r.protocol_error = 1;
      if (addr_cnt < 4) addr_hist[addr_cnt] = it.write_data;
      if (addr_cnt < CNT_SAT) addr_cnt++;
    end else if (cmd_cnt == 0) begin
      r.protocol_error = 1;
    end else begin
      if (cmd_hist[0] == CMD_READ_SPARE || cmd_hist[0] == CMD_READ0)
        r.protocol_error = !(cmd_cnt >= 2 && cmd_hist[1] == CMD_PROG);
      else
        r.protocol_error = 1;
      if (data_cnt < BUFFER_BYTES) begin
        data_buf[data_cnt] = it.write_data;
        data_cnt++;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    nfce_out_t exp_item;
    if (!rst_n) begin
      cmd_hist  = '{default: '0};
      addr_hist = '{default: '0};
      clear_counts();
      overwrite = 0;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) overwrite = cfg_wr_data;
      if (start && !busy) expected_q = {expected_q, flash_access(in_item)};
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: read_data %h protocol_error %b",
                 out_item.read_data, out_item.protocol_error);
          fail_count++;
        end else begin
          exp_item = expected_q.pop_front();
          if (out_item.read_data !== exp_item.read_data) begin
            $error("read_data: expected %h actual %h", exp_item.read_data, out_item.read_data);
            fail_count++;
          end
          if (out_item.protocol_error !== exp_item.protocol_error) begin
            $error("protocol_error: expected %b actual %b",
                   exp_item.protocol_error, out_item.protocol_error);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

/* tb/testbench.sv */
module testbench;
  import nfce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PAGES    = 1024;
  localparam int BLOCK_PAGES  = 32;
  localparam int BUFFER_BYTES = 544;
  // idle limit is generous, well above the clearing pass and an erase
  localparam int IDLE_LIMIT   = 2000000;
  localparam int ITEM_TARGET  = 1500;
  localparam int ERASE_BUDGET = 14;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      start = 0;
  logic      busy;
  nfce_in_t  in_item = '0;
  logic      out_valid;
  nfce_out_t out_item;
  logic      cfg_wr_en = 0;
  logic      cfg_wr_data = 0;
  int        fail_count;
  int        pending;

  int burst_left = 0;
  int item_count = 0;
  int erase_count = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  nand_flash_command_engine_core #(
    .NUM_PAGES(NUM_PAGES), .BLOCK_PAGES(BLOCK_PAGES), .BUFFER_BYTES(BUFFER_BYTES)
  ) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  nfce_checker #(
    .NUM_PAGES(NUM_PAGES), .BLOCK_PAGES(BLOCK_PAGES), .BUFFER_BYTES(BUFFER_BYTES)
  ) checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending(pending)
  );

  // watchdog: any cycle out of reset with no item taken and no result counts toward the limit
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // one bus access, sender works in bursts with random gaps
  task automatic bus_item(logic act, logic c, logic a, logic [7:0] d);
    nfce_in_t it;
    if (burst_left == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // some bursts long enough to run with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    it.action = act;
    it.cle = c;
    it.ale = a;
    it.write_data = d;
    start <= 1;
    in_item <= it;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    item_count++;
  endtask

  task automatic cmd(logic [7:0] v);
    bus_item(1'b1, 1'b1, 1'b0, v);
  endtask

  task automatic addr(logic [7:0] v);
    bus_item(1'b1, 1'b0, 1'b1, v);
  endtask

  task automatic dat(logic [7:0] v);
    bus_item(1'b1, 1'b0, 1'b0, v);
  endtask

  task automatic rd();
    bus_item(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             8'($urandom_range(0, 255)));
  endtask

  // mostly the first two blocks so reads meet programmed bytes, sometimes far or off the end
  function automatic int pick_page();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, NUM_PAGES - 1);
      1: return $urandom_range(NUM_PAGES, (1 << PAGE_W) - 1);
      default: return $urandom_range(0, 63);
    endcase
  endfunction

  task automatic row_addr(int pg, logic [7:0] col);
    addr(col);
    addr(pg[7:0]);
    addr(pg[15:8]);
    addr({7'($urandom), pg[16]});
  endtask

  task automatic page_read(logic [7:0] op, int pg, logic [7:0] col, int n);
    cmd(op);
    row_addr(pg, col);
    repeat (n) rd();
  endtask

  task automatic spare_program(int pg, logic [7:0] col);
    cmd(CMD_READ_SPARE);
    cmd(CMD_PROG);
    row_addr(pg, col);
    repeat (SPARE_BYTES) dat(8'($urandom_range(0, 255)));
    cmd(CMD_PROG_CONF);
  endtask

  task automatic full_program(int pg);
    cmd(CMD_READ0);
    cmd(CMD_PROG);
    row_addr(pg, 8'h00);
    repeat (PAGE_BYTES) dat(8'($urandom_range(0, 255)));
    cmd(CMD_PROG_CONF);
  endtask

  task automatic block_erase(int pg);
    cmd(CMD_ERASE);
    addr(pg[7:0]);
    addr(pg[15:8]);
    addr({7'($urandom), pg[16]});
    cmd(CMD_ERASE_CONF);
    erase_count++;
  endtask

  // register write only with nothing in flight and the block idle
  task automatic set_overwrite(logic v);
    start <= 0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic random_sequence();
    int pg;
    int kind;
    pg = pick_page();
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      page_read(($urandom_range(0, 2) == 0) ? CMD_READ0 :
                ($urandom_range(0, 1) ? CMD_READ1 : CMD_READ_SPARE),
                pg, 8'($urandom_range(0, 255)), $urandom_range(1, 20));
    end else if (kind < 55) begin
      spare_program(pg, 8'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : 0));
      // read it back
      page_read(CMD_READ_SPARE, pg, 8'h00, $urandom_range(4, 16));
    end else if (kind < 60 && erase_count < ERASE_BUDGET) begin
      block_erase(($urandom_range(0, 3) == 0) ? pg : pg & ~(BLOCK_PAGES - 1));
      cmd(CMD_STATUS);
      rd();
    end else if (kind < 66) begin
      cmd(CMD_STATUS);
      repeat ($urandom_range(1, 2)) rd();
    end else if (kind < 72) begin
      cmd(CMD_READ_ID);
      addr(8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0));
      repeat ($urandom_range(1, 4)) rd();
    end else if (kind < 82) begin
      // broken sequences: cut short, then a confirm or a reset
      cmd($urandom_range(0, 1) ? CMD_READ_SPARE : CMD_READ0);
      if ($urandom_range(0, 1)) cmd(CMD_PROG);
      repeat ($urandom_range(0, 5)) addr(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 6)) dat(8'($urandom_range(0, 255)));
      cmd($urandom_range(0, 1) ? CMD_PROG_CONF : CMD_RESET);
    end else begin
      // noise
      repeat ($urandom_range(1, 8))
        bus_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 1) ? $urandom_range(0, 255) :
                    ($urandom_range(0, 1) ? CMD_PROG_CONF : CMD_ERASE_CONF)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // directed: empty command, status, id and its overrun
    rd();
    cmd(CMD_STATUS);
    rd();
    cmd(CMD_READ_ID);
    addr(8'h00);
    rd();
    rd();
    cmd(CMD_READ_ID);
    addr(8'h00);
    rd();
    rd();
    rd();
    // unknown command, then reads in the wrong state
    cmd(8'h33);
    rd();
    cmd(CMD_ERASE);
    rd();
    // both latch enables, data and address without a command
    cmd(CMD_RESET);
    bus_item(1'b1, 1'b1, 1'b1, 8'hFF);
    dat(8'hFF);
    addr(8'h00);
    cmd(CMD_RESET);
    cmd(CMD_PROG_CONF);
    cmd(CMD_ERASE_CONF);
    cmd(CMD_PROG);
    cmd(CMD_RESET);
    // full page program at the array's last page, read it back through both half-page read commands
    full_program(NUM_PAGES - 1);
    page_read(CMD_READ0, NUM_PAGES - 1, 8'hFF, 3);
    page_read(CMD_READ1, NUM_PAGES - 1, 8'h00, 2);
    // spare program with a nonzero column, off-end page, unaligned erase
    spare_program(0, 8'h03);
    page_read(CMD_READ_SPARE, 0, 8'h00, 6);
    spare_program((1 << PAGE_W) - 1, 8'h00);
    page_read(CMD_READ_SPARE, (1 << PAGE_W) - 1, 8'h00, 2);
    block_erase(5);
    page_read(CMD_READ_SPARE, 0, 8'h00, 2);

    set_overwrite(1'b1);
    spare_program(1, 8'h00);
    spare_program(1, 8'h00);
    page_read(CMD_READ_SPARE, 1, 8'h00, 16);
    full_program(2);
    page_read(CMD_READ0, 2, 8'h00, 8);

    // random part in phases, overwrite mode toggled between them
    for (int phase = 0; phase < 4; phase++) begin
      while (item_count < ITEM_TARGET * (phase + 1) / 4) random_sequence();
      set_overwrite(phase[0]);
    end

    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
